FILE: rtl/core/wsfu_pkg.sv
// Package for the frame unmasker core: transfer payload types, header constants.
// No dependencies; used by every file in rtl/core.
package wsfu_pkg;

	// Frame header constants
	localparam logic [7:0] FRAME_TEXT_FIN = 8'h81;
	localparam logic [7:0] MASK_BIT       = 8'h80;
	localparam logic [6:0] LEN7_EXT16     = 7'h7E;
	localparam logic [6:0] LEN7_EXT64     = 7'h7F;

	// Extended-length byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_data;
		logic       end_of_packet;
	} out_item_t;

	// Handshake between the input stage and the step unit
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

FILE: rtl/core/wsfu_step.sv
// Frame parser and unmasking step with its result register.
// Depends on wsfu_pkg.
module wsfu_step (
	input  logic               clk,
	input  logic               arst_n,
	input  wsfu_pkg::in_item_t item_s1,
	input  logic               valid_s1,
	output logic               advance_s1,
	output wsfu_pkg::out_item_t result,
	output logic               result_valid,
	input  logic               result_ready
);

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DROP    = 3'd5
	} phase_t;

	phase_t              phase_q, phase_nxt;
	logic [3:0]          hdr_cnt_q, hdr_cnt_nxt, hdr_cnt_dec, hdr_cnt_inc;
	logic [31:0]         mask_key_q, mask_key_nxt;
	logic [1:0]          pay_idx_q, pay_idx_nxt;
	wsfu_pkg::out_item_t res_q, res_nxt;
	logic                res_valid_q;
	logic                emit;
	logic                can_load;
	logic [7:0]          key_byte;

	assign can_load   = !res_valid_q || result_ready;
	assign advance_s1 = valid_s1 && can_load;

	assign hdr_cnt_dec = hdr_cnt_q - 4'd1;
	assign hdr_cnt_inc = hdr_cnt_q + 4'd1;
	assign key_byte    = mask_key_q[{pay_idx_q, 3'b000} +: 8];

	always_comb begin
		phase_nxt    = phase_q;
		hdr_cnt_nxt  = hdr_cnt_q;
		mask_key_nxt = mask_key_q;
		pay_idx_nxt  = pay_idx_q;
		res_nxt      = '0;
		case (phase_q)
			PH_FIRST: begin
				phase_nxt   = (item_s1.data_byte == wsfu_pkg::FRAME_TEXT_FIN) ?
					PH_SECOND : PH_DROP;
				hdr_cnt_nxt = '0;
				pay_idx_nxt = '0;
			end
			PH_SECOND: begin
				if ((item_s1.data_byte & wsfu_pkg::MASK_BIT) == 8'h00) begin
					phase_nxt = PH_DROP;
				end else if (item_s1.data_byte[6:0] == wsfu_pkg::LEN7_EXT16) begin
					phase_nxt   = PH_EXTLEN;
					hdr_cnt_nxt = wsfu_pkg::EXT16_BYTES;
				end else if (item_s1.data_byte[6:0] == wsfu_pkg::LEN7_EXT64) begin
					phase_nxt   = PH_EXTLEN;
					hdr_cnt_nxt = wsfu_pkg::EXT64_BYTES;
				end else begin
					phase_nxt   = PH_MASK;
					hdr_cnt_nxt = '0;
				end
			end
			PH_EXTLEN: begin
				hdr_cnt_nxt = hdr_cnt_dec;
				if (hdr_cnt_dec == 4'd0) begin
					phase_nxt = PH_MASK;
				end
			end
			PH_MASK: begin
				mask_key_nxt[{hdr_cnt_q[1:0], 3'b000} +: 8] = item_s1.data_byte;
				hdr_cnt_nxt = hdr_cnt_inc;
				if (hdr_cnt_inc >= wsfu_pkg::MASK_BYTES) begin
					phase_nxt   = PH_PAYLOAD;
					hdr_cnt_nxt = '0;
					pay_idx_nxt = '0;
				end
			end
			PH_PAYLOAD: begin
				res_nxt.payload_byte = item_s1.data_byte ^ key_byte;
				res_nxt.has_data     = 1'b1;
				pay_idx_nxt          = pay_idx_q + 2'd1;
			end
			default: begin
				// drop until the end of the buffer
			end
		endcase
		res_nxt.end_of_packet = item_s1.last_byte;
		// restart on the buffer's last byte; the key is rewritten before reuse
		if (item_s1.last_byte) begin
			phase_nxt   = PH_FIRST;
			hdr_cnt_nxt = '0;
			pay_idx_nxt = '0;
		end
	end

	assign emit = res_nxt.has_data || item_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			hdr_cnt_q   <= '0;
			mask_key_q  <= '0;
			pay_idx_q   <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (advance_s1) begin
				phase_q    <= phase_nxt;
				hdr_cnt_q  <= hdr_cnt_nxt;
				mask_key_q <= mask_key_nxt;
				pay_idx_q  <= pay_idx_nxt;
			end
			if (can_load) begin
				res_valid_q <= advance_s1 && emit;
			end
			if (advance_s1 && emit) begin
				res_q <= res_nxt;
			end
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

endmodule

FILE: rtl/core/websocket_frame_unmasker_core.sv
// Top level of the frame unmasker: input register plus the parse/unmask step.
// Depends on wsfu_pkg and wsfu_step.
//
//   channel | direction | payload type          | handshake
//   item    | in        | wsfu_pkg::in_item_t   | item_valid / item_ready
//   result  | out       | wsfu_pkg::out_item_t  | result_valid / result_ready
//
// One byte per clock sustained while results are taken. A byte's result passes
// through the input register and then the result register before it can
// transfer out.
// Header bytes that are not a buffer's last byte give no result.
// Reset (arst_n low) returns to waiting for a first header byte.
// A stalled result holds the result register; one more byte waits in the input
// register, then item_ready drops until the result is taken.
module websocket_frame_unmasker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  wsfu_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output wsfu_pkg::out_item_t result
);

	wsfu_pkg::in_item_t  item_s1;
	wsfu_pkg::stage_ctl_t ctl_s1;
	logic                valid_s1;
	logic                advance_s1;

	assign ctl_s1.valid   = valid_s1;
	assign ctl_s1.advance = advance_s1;

	// Accept when the input register is empty or drains this cycle
	assign item_ready = !ctl_s1.valid || ctl_s1.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else begin
			if (item_valid && item_ready) begin
				// take the new transfer
				valid_s1 <= 1'b1;
				item_s1  <= item;
			end else if (ctl_s1.advance) begin
				// drain
				valid_s1 <= 1'b0;
			end
		end
	end

	wsfu_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.valid_s1     (ctl_s1.valid),
		.advance_s1   (advance_s1),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

FILE: rtl/core/wsfu_checker.sv
// Port-level checks for the frame unmasker core, bound to the top level.
// Depends on wsfu_pkg and websocket_frame_unmasker_core.
module wsfu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input wsfu_pkg::out_item_t result
);

	// A stalled result holds its valid
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped before transfer");

	// A stalled result holds its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed before transfer");

	// Input backpressure only comes from a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item_ready low without output stall");

	// A result without data marks the end of a packet
	a_nodata_eop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_data |-> result.end_of_packet)
		else $error("empty result without end_of_packet");

	// A result without data carries a zero byte
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_data |-> result.payload_byte == 8'h00)
		else $error("nonzero payload_byte without data");

endmodule

bind websocket_frame_unmasker_core wsfu_checker u_wsfu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: bench/websocket_frame_unmasker_core_test.sv
// Self-checking testbench for websocket_frame_unmasker_core: drives frame buffers byte by byte
// and checks each result against an in-bench frame parser and unmasker.
// Depends on wsfu_pkg and the RTL of the core; reads no files.
`timescale 1ns / 100ps

module websocket_frame_unmasker_core_test;

	// Parser phases of the in-bench unmasker
	typedef enum logic [2:0] {
		AWAIT_FIN_OP,
		AWAIT_LEN,
		SKIP_EXT_LEN,
		LOAD_KEY,
		UNMASK_DATA,
		DISCARD
	} parse_phase_t;

	localparam int unsigned HOLD_OFF_CYCLES = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	wsfu_pkg::in_item_t  item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	wsfu_pkg::out_item_t result;

	// Parser state, mirrors what the core keeps between bytes
	parse_phase_t parse_phase = AWAIT_FIN_OP;
	logic [3:0]   hdr_count = '0;
	logic [31:0]  key_bytes = '0;
	logic [1:0]   data_index = '0;

	// Results still owed by the core, oldest at owed_rd
	wsfu_pkg::out_item_t owed[0:63];
	logic [5:0]          owed_wr = '0;
	logic [5:0]          owed_rd = '0;
	wsfu_pkg::out_item_t oldest_result;

	// Bytes of the buffer being built
	logic [7:0]  frame_buf[0:63];
	int unsigned frame_len = 0;

	bit          sender_idle = 1'b1;
	bit          receiver_idle = 1'b1;
	int unsigned hold_request = 0;

	int unsigned frames_sent = 0;
	int unsigned bytes_sent = 0;
	int unsigned results_checked = 0;
	int unsigned data_results = 0;
	int unsigned mismatches = 0;

	websocket_frame_unmasker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Advance the parser by one byte; emits is set when the byte yields a result.
	function automatic void unmask_step(input wsfu_pkg::in_item_t it, output bit emits,
			output wsfu_pkg::out_item_t res);
		res = '0;
		emits = 1'b0;
		case (parse_phase)
		AWAIT_FIN_OP: begin
			parse_phase = (it.data_byte == wsfu_pkg::FRAME_TEXT_FIN) ? AWAIT_LEN : DISCARD;
			hdr_count = '0;
			data_index = '0;
		end
		AWAIT_LEN: begin
			if ((it.data_byte & wsfu_pkg::MASK_BIT) == 8'h00) begin
				parse_phase = DISCARD;
			end else if (it.data_byte[6:0] == wsfu_pkg::LEN7_EXT16) begin
				parse_phase = SKIP_EXT_LEN;
				hdr_count = wsfu_pkg::EXT16_BYTES;
			end else if (it.data_byte[6:0] == wsfu_pkg::LEN7_EXT64) begin
				parse_phase = SKIP_EXT_LEN;
				hdr_count = wsfu_pkg::EXT64_BYTES;
			end else begin
				parse_phase = LOAD_KEY;
				hdr_count = '0;
			end
		end
		SKIP_EXT_LEN: begin
			hdr_count = hdr_count - 4'd1;
			if (hdr_count == 4'd0)
				parse_phase = LOAD_KEY;
		end
		LOAD_KEY: begin
			// key byte i sits in bits 8i+7..8i
			key_bytes[{hdr_count[1:0], 3'b000} +: 8] = it.data_byte;
			hdr_count = hdr_count + 4'd1;
			if (hdr_count >= wsfu_pkg::MASK_BYTES) begin
				parse_phase = UNMASK_DATA;
				hdr_count = '0;
				data_index = '0;
			end
		end
		UNMASK_DATA: begin
			res.payload_byte = it.data_byte ^ key_bytes[{data_index, 3'b000} +: 8];
			res.has_data = 1'b1;
			emits = 1'b1;
			data_index = data_index + 2'd1;
		end
		default: ;
		endcase
		// The buffer's last byte always closes the packet; the key is left alone
		if (it.last_byte) begin
			parse_phase = AWAIT_FIN_OP;
			hdr_count = '0;
			data_index = '0;
			res.end_of_packet = 1'b1;
			emits = 1'b1;
		end
	endfunction

	// Offer one byte, hold it until transferred, then log what it should produce.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned         gap;
		wsfu_pkg::in_item_t  it;
		wsfu_pkg::out_item_t res;
		bit                  emits;
		gap = 0;
		if (sender_idle && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.data_byte = b;
		it.last_byte = last;
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_ready !== 1'b1)
			@(posedge clk);
		unmask_step(it, emits, res);
		if (emits) begin
			owed[owed_wr] = res;
			owed_wr = owed_wr + 6'd1;
		end
		bytes_sent++;
	endtask

	// Send the built buffer, flagging its final byte.
	task automatic send_buffer();
		for (int unsigned i = 0; i < frame_len; i++)
			send_byte(frame_buf[6'(i)], i == frame_len - 1);
		frames_sent++;
		frame_len = 0;
	endtask

	// Append one byte to the buffer being built.
	function automatic void add_byte(input logic [7:0] b);
		frame_buf[6'(frame_len)] = b;
		frame_len++;
	endfunction

	function automatic void put_random(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			add_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_key(input logic [31:0] k);
		for (int i = 0; i < 4; i++)
			add_byte(k[8 * i +: 8]);
	endfunction

	// Build one buffer: mostly good frames with random header form, key and payload,
	// plus rejected, cut-short and noise buffers.
	task automatic random_frame();
		int unsigned pick;
		int unsigned form;
		int unsigned n_payload;
		int unsigned cut;
		logic [6:0]  len7;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			put_random($urandom_range(1, 6));
		end else if (pick < 10) begin
			add_byte(8'($urandom_range(0, 255)));
			if (frame_buf[0] == wsfu_pkg::FRAME_TEXT_FIN)
				frame_buf[0] = 8'h01;
			put_random($urandom_range(0, 8));
		end else if (pick < 14) begin
			add_byte(wsfu_pkg::FRAME_TEXT_FIN);
			add_byte({1'b0, 7'($urandom_range(0, 127))});
			put_random($urandom_range(0, 8));
		end else begin
			n_payload = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40)
				: $urandom_range(0, 10);
			form = $urandom_range(0, 99);
			if (form < 70)
				len7 = ($urandom_range(0, 1) == 0) ? 7'(n_payload) : 7'($urandom_range(0, 125));
			else if (form < 85)
				len7 = wsfu_pkg::LEN7_EXT16;
			else
				len7 = wsfu_pkg::LEN7_EXT64;
			add_byte(wsfu_pkg::FRAME_TEXT_FIN);
			add_byte(wsfu_pkg::MASK_BIT | {1'b0, len7});
			if (len7 == wsfu_pkg::LEN7_EXT16)
				put_random(32'(wsfu_pkg::EXT16_BYTES));
			else if (len7 == wsfu_pkg::LEN7_EXT64)
				put_random(32'(wsfu_pkg::EXT64_BYTES));
			put_key($urandom());
			put_random(n_payload);
			// Cut the buffer short somewhere inside the header or payload
			if (pick < 22 && frame_len > 1) begin
				cut = $urandom_range(1, frame_len - 1);
				frame_len = cut;
			end
		end
		send_buffer();
	endtask

	// Check every result transfer against the oldest owed result.
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready === 1'b1) begin
			if (owed_wr == owed_rd) begin
				report_mismatch($sformatf("result %h with nothing owed", result));
			end else begin
				oldest_result = owed[owed_rd];
				owed_rd = owed_rd + 6'd1;
				results_checked++;
				if (oldest_result.has_data)
					data_results++;
				if (result.payload_byte !== oldest_result.payload_byte)
					report_mismatch($sformatf("payload_byte %h, want %h",
						result.payload_byte, oldest_result.payload_byte));
				if (result.has_data !== oldest_result.has_data)
					report_mismatch($sformatf("has_data %b, want %b",
						result.has_data, oldest_result.has_data));
				if (result.end_of_packet !== oldest_result.end_of_packet)
					report_mismatch($sformatf("end_of_packet %b, want %b",
						result.end_of_packet, oldest_result.end_of_packet));
			end
		end
	end

	// Drive result_ready: random stall bursts, or a long hold-off when asked.
	initial begin : drive_result_ready
		int unsigned span;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				result_ready <= 1'b0;
				span = hold_request;
				repeat (span) @(posedge clk);
				hold_request = 0;
				result_ready <= 1'b1;
			end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
				result_ready <= 1'b0;
				span = $urandom_range(1, 15);
				repeat (span) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Longest header (64-bit length), extreme byte values, key index wrapping past four.
	task automatic test_long_header();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		add_byte(8'hFF);
		put_random(32'(wsfu_pkg::EXT64_BYTES));
		put_key(32'h5AA500FF);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h3C);
		add_byte(8'hC3);
		add_byte(8'h12);
		send_buffer();
	endtask

	// 16-bit extended length, then a zero-length frame that ends on its last key byte.
	task automatic test_short_headers();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		add_byte(8'hFE);
		add_byte(8'h00);
		add_byte(8'h01);
		put_key($urandom());
		put_random(1);
		send_buffer();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		add_byte(wsfu_pkg::MASK_BIT);
		put_key($urandom());
		send_buffer();
	endtask

	// Wrong first byte and a clear mask bit: the buffer is dropped.
	task automatic test_rejected_frames();
		add_byte(8'h00);
		add_byte(8'hFF);
		send_buffer();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		add_byte(8'h7F);
		add_byte(8'h55);
		send_buffer();
	endtask

	// Buffers that end inside the header.
	task automatic test_cut_short();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		send_buffer();
		add_byte(wsfu_pkg::FRAME_TEXT_FIN);
		add_byte(8'hFE);
		add_byte(8'h00);
		send_buffer();
	endtask

	// Random buffers with idling switched on and off in stretches.
	task automatic test_random_frames(input int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned n_frames;
		stop_at = bytes_sent + n_bytes;
		n_frames = 0;
		while (bytes_sent < stop_at) begin
			if (n_frames % 8 == 0) begin
				sender_idle = ($urandom_range(0, 3) != 0);
				receiver_idle = ($urandom_range(0, 3) != 0);
			end
			random_frame();
			n_frames++;
		end
	endtask

	// Hold the output off for a long stretch while bytes keep coming.
	task automatic test_backpressure();
		sender_idle = 1'b0;
		hold_request = HOLD_OFF_CYCLES;
		repeat (6)
			random_frame();
	endtask

	task automatic test_random_frames_steady(input int unsigned n_bytes);
		int unsigned stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			random_frame();
	endtask

	// Full rate on both sides to finish.
	task automatic test_steady_stream(input int unsigned n_bytes);
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		test_random_frames_steady(n_bytes);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_long_header();
		test_short_headers();
		test_rejected_frames();
		test_cut_short();
		test_random_frames(600);
		test_backpressure();
		test_random_frames(120);
		test_steady_stream(120);

		item_valid <= 1'b0;
		while (owed_wr != owed_rd)
			@(posedge clk);
		// let any stray result surface
		repeat (10) @(posedge clk);
		if (owed_wr != owed_rd)
			report_mismatch($sformatf("%0d results never arrived", 6'(owed_wr - owed_rd)));

		$display("Sent %0d buffers, %0d bytes; checked %0d results, %0d with payload.",
			frames_sent, bytes_sent, results_checked, data_results);
		$display("Headers short/16-bit/64-bit, rejected and cut-short buffers, %0d-cycle stall.",
			HOLD_OFF_CYCLES);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#6_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
